>>> sv/triangle_unit_normal_macros.svh
// assertion macros for the triangle unit normal block
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tun assertion failed");
`define TUN_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("tun assertion failed");
`else
`define TUN_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define TUN_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> sv/tun_pkg.sv
// shared types and constants of the triangle unit normal block
package tun_pkg;
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;
   localparam int MAG_BITS    = 31;
   localparam int SQ_WIDTH    = 2 * MAG_BITS;
   localparam int SUM_WIDTH   = SQ_WIDTH + 2;
   localparam int FRAC_BITS   = 14;
   localparam int Q_WIDTH     = FRAC_BITS + 1;
   localparam int OUT_WIDTH   = 16;
   localparam int ACC_WIDTH   = SUM_WIDTH + 2 * FRAC_BITS + 4;
   localparam int SHIFT_WIDTH = $clog2(CROSS_WIDTH + 1);
   localparam logic signed [OUT_WIDTH-1:0] UNIT_ONE = OUT_WIDTH'(1 << FRAC_BITS);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [OUT_WIDTH-1:0] unit_type;

   typedef struct packed {
      coord_type ax, ay, az;
      coord_type bx, by_coord, bz;
      coord_type cx, cy, cz;
   } tri_type;

   typedef struct packed {
      logic [ACC_WIDTH-1:0] rem;
      logic [ACC_WIDTH-1:0] acc;
      logic [Q_WIDTH-1:0]   q;
      logic                 neg;
   } lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 degenerate;
      logic [ACC_WIDTH-1:0] step;
      lane_type [2:0]       lane;
   } cell_word_type;
endpackage

>>> sv/tun_if.sv
// request and response channel interfaces
interface tun_req_if;
   import tun_pkg::*;
   logic      valid;
   logic      ready;
   coord_type ax, ay, az;
   coord_type bx, by_coord, bz;
   coord_type cx, cy, cz;
   modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
   modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tun_rsp_if;
   import tun_pkg::*;
   logic     valid;
   logic     ready;
   unit_type nx, ny, nz;
   logic     degenerate;
   modport source (output valid, nx, ny, nz, degenerate, input ready);
   modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface

>>> sv/triangle_unit_normal.sv
// top level of the triangle unit normal block
// Takes one triangle per cycle unless the response channel stalls, and returns its unit face normal in signed Q1.14,
// each component rounded toward zero, with a flag for a zero-area triangle. The
// pipeline has seven front stages that form the cross product and the
// scaled squares, a chain of fifteen cells that settle one quotient bit each, and a
// last register that holds the word for the sink. Back-pressure on the response
// channel stalls the whole pipeline.
module triangle_unit_normal (
   input logic       clock,
   input logic       reset,
   tun_req_if.sink   req_ch,
   tun_rsp_if.source rsp_ch
);
   import tun_pkg::*;
`include "triangle_unit_normal_macros.svh"

   logic          advance;
   tri_type       tri_word;
   cell_word_type chain [Q_WIDTH+1];
   logic          out_valid_ff;
   unit_type      n_ff [3], n_in [3];
   logic          deg_ff;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_comb begin
      tri_word.ax       = req_ch.ax;
      tri_word.ay       = req_ch.ay;
      tri_word.az       = req_ch.az;
      tri_word.bx       = req_ch.bx;
      tri_word.by_coord = req_ch.by_coord;
      tri_word.bz       = req_ch.bz;
      tri_word.cx       = req_ch.cx;
      tri_word.cy       = req_ch.cy;
      tri_word.cz       = req_ch.cz;
   end

   tun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_ch.valid),
      .in_tri   (tri_word),
      .out_word (chain[0])
   );

   for (genvar g = 0; g < Q_WIDTH; g++) begin : g_cell
      tun_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_word  (chain[g]),
         .out_word (chain[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (chain[Q_WIDTH].degenerate) begin
            n_in[i] = '0;
         end else if (chain[Q_WIDTH].lane[i].neg) begin
            n_in[i] = -$signed({{(OUT_WIDTH-Q_WIDTH){1'b0}}, chain[Q_WIDTH].lane[i].q});
         end else begin
            n_in[i] = $signed({{(OUT_WIDTH-Q_WIDTH){1'b0}}, chain[Q_WIDTH].lane[i].q});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[Q_WIDTH].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff   <= n_in;
         deg_ff <= chain[Q_WIDTH].degenerate;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.nx         = n_ff[0];
   assign rsp_ch.ny         = n_ff[1];
   assign rsp_ch.nz         = n_ff[2];
   assign rsp_ch.degenerate = deg_ff;

   `TUN_ASSERT_IMPLIES(a_deg_zero, clock, reset, rsp_ch.valid && rsp_ch.degenerate, rsp_ch.nx == 0 && rsp_ch.ny == 0 && rsp_ch.nz == 0)
   `TUN_ASSERT_IMPLIES(a_unit_range, clock, reset, rsp_ch.valid, rsp_ch.nx <= UNIT_ONE && rsp_ch.nx >= -UNIT_ONE && rsp_ch.nz <= UNIT_ONE && rsp_ch.nz >= -UNIT_ONE)
   `TUN_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(n_ff[1]) && $stable(deg_ff))
endmodule

>>> sv/tun_front.sv
// front pipeline: edge vectors, cross product, scaling and squares
module tun_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  tun_pkg::tri_type       in_tri,
   output tun_pkg::cell_word_type out_word
);
   import tun_pkg::*;

   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                          s4_valid_ff, s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic signed [DIFF_WIDTH-1:0]  u_ff [3], u_in [3];
   logic signed [DIFF_WIDTH-1:0]  v_ff [3], v_in [3];
   logic signed [PROD_WIDTH-1:0]  p_ff [6], p_in [6];
   logic signed [CROSS_WIDTH-1:0] c_ff [3], c_in [3];
   logic [CROSS_WIDTH-1:0]        mag_ff [3], mag_in [3];
   logic [2:0]                    neg4_ff, neg5_ff, neg6_ff, neg_in;
   logic                          deg4_ff, deg5_ff, deg6_ff, deg_in;
   logic [MAG_BITS-1:0]           m_ff [3], m_in [3];
   logic [SQ_WIDTH-1:0]           sq_ff [3], sq_in [3];
   logic [CROSS_WIDTH-1:0]        mag_or;
   logic [SHIFT_WIDTH-1:0]        shift;
   logic [SUM_WIDTH-1:0]          sum;
   cell_word_type                 word_ff, word_in;

   function automatic logic signed [DIFF_WIDTH-1:0] diff(coord_type a, coord_type b);
      logic signed [DIFF_WIDTH-1:0] ea, eb;
      ea = $signed({a[COORD_WIDTH-1], a});
      eb = $signed({b[COORD_WIDTH-1], b});
      return ea - eb;
   endfunction

   always_comb begin
      u_in[0] = diff(in_tri.ax, in_tri.bx);
      u_in[1] = diff(in_tri.ay, in_tri.by_coord);
      u_in[2] = diff(in_tri.az, in_tri.bz);
      v_in[0] = diff(in_tri.bx, in_tri.cx);
      v_in[1] = diff(in_tri.by_coord, in_tri.cy);
      v_in[2] = diff(in_tri.bz, in_tri.cz);
      p_in[0] = u_ff[1] * v_ff[2];
      p_in[1] = u_ff[2] * v_ff[1];
      p_in[2] = u_ff[2] * v_ff[0];
      p_in[3] = u_ff[0] * v_ff[2];
      p_in[4] = u_ff[0] * v_ff[1];
      p_in[5] = u_ff[1] * v_ff[0];
      for (int i = 0; i < 3; i++) begin
         c_in[i] = $signed({p_ff[2*i][PROD_WIDTH-1], p_ff[2*i]})
                 - $signed({p_ff[2*i+1][PROD_WIDTH-1], p_ff[2*i+1]});
         neg_in[i] = c_ff[i][CROSS_WIDTH-1];
         mag_in[i] = neg_in[i] ? CROSS_WIDTH'(-c_ff[i]) : CROSS_WIDTH'(c_ff[i]);
      end
      deg_in = (c_ff[0] == '0) && (c_ff[1] == '0) && (c_ff[2] == '0);
      // bring all three magnitudes below 2^31 with one common shift
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      shift  = '0;
      for (int i = MAG_BITS; i < CROSS_WIDTH; i++) begin
         if (mag_or[i]) begin
            shift = SHIFT_WIDTH'(i - (MAG_BITS - 1));
         end
      end
      for (int i = 0; i < 3; i++) begin
         m_in[i]  = MAG_BITS'({{MAG_BITS{1'b0}}, mag_ff[i]} >> shift);
         sq_in[i] = m_ff[i] * m_ff[i];
      end
      sum = SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
      word_in.valid      = s6_valid_ff;
      word_in.degenerate = deg6_ff;
      word_in.step       = ACC_WIDTH'(sum) << (2 * FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         word_in.lane[i].rem = ACC_WIDTH'(sq_ff[i]) << (2 * FRAC_BITS);
         word_in.lane[i].acc = '0;
         word_in.lane[i].q   = '0;
         word_in.lane[i].neg = neg6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff    <= u_in;
         v_ff    <= v_in;
         p_ff    <= p_in;
         c_ff    <= c_in;
         mag_ff  <= mag_in;
         neg4_ff <= neg_in;
         deg4_ff <= deg_in;
         m_ff    <= m_in;
         neg5_ff <= neg4_ff;
         deg5_ff <= deg4_ff;
         sq_ff   <= sq_in;
         neg6_ff <= neg5_ff;
         deg6_ff <= deg5_ff;
         word_ff <= word_in;
      end
   end

   always_comb begin
      out_word       = word_ff;
      out_word.valid = s7_valid_ff;
   end
endmodule

>>> sv/tun_cell.sv
// one quotient bit of the three normal components
module tun_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tun_pkg::cell_word_type in_word,
   output tun_pkg::cell_word_type out_word
);
   import tun_pkg::*;

   cell_word_type        word_ff, word_in;
   logic                 valid_ff;
   logic [ACC_WIDTH-1:0] trial [3];
   logic [2:0]           take;

   // trial cost of setting this bit is acc + step, taken when it fits the remainder
   always_comb begin
      word_in      = in_word;
      word_in.step = in_word.step >> 2;
      for (int i = 0; i < 3; i++) begin
         trial[i] = in_word.lane[i].acc + in_word.step;
         take[i]  = trial[i] <= in_word.lane[i].rem;
         word_in.lane[i].rem = take[i] ? in_word.lane[i].rem - trial[i] : in_word.lane[i].rem;
         word_in.lane[i].acc = (take[i] ? in_word.lane[i].acc + (in_word.step << 1)
                                        : in_word.lane[i].acc) >> 1;
         word_in.lane[i].q   = {in_word.lane[i].q[Q_WIDTH-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   always_comb begin
      out_word       = word_ff;
      out_word.valid = valid_ff;
   end
endmodule

>>> tb/tun_tb_if.sv
// channel interfaces used by the testbench live in the rtl; this file holds the word type used by the tb checker
package tun_tb_pkg;
   import tun_pkg::*;
   typedef struct {
      unit_type nx, ny, nz;
      logic     degenerate;
   } normal_word_type;
endpackage

>>> tb/triangle_unit_normal_checker.sv
// checker that predicts the unit normal of each accepted triangle and compares responses
module triangle_unit_normal_checker
   import tun_pkg::*;
   import tun_tb_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   tun_req_if     req_ch,
   tun_rsp_if     rsp_ch,
   output int     fail_count,
   output int     pending
);
   normal_word_type normal_queue[$];

   function automatic logic [63:0] unit_component(logic [63:0] m, logic [63:0] s);
      logic [127:0] rhs;
      logic [127:0] lhs;
      logic [63:0]  q;
      logic [63:0]  t;
      rhs = {64'd0, m * m} << 28;
      q = 0;
      for (int b = 14; b >= 0; b--) begin
         t = q | (64'd1 << b);
         lhs = {64'd0, t * t} * {64'd0, s};
         if (lhs <= rhs) q = t;
      end
      return q;
   endfunction

   function automatic normal_word_type face_normal(tri_type t);
      normal_word_type w;
      logic signed [63:0]  ux, uy, uz, vx, vy, vz;
      logic signed [127:0] c[3];
      logic [127:0]        a[3];
      logic                neg[3];
      logic [63:0]         m[3];
      logic [63:0]         s;
      logic [63:0]         q;
      ux = t.ax - t.bx; uy = t.ay - t.by_coord; uz = t.az - t.bz;
      vx = t.bx - t.cx; vy = t.by_coord - t.cy; vz = t.bz - t.cz;
      c[0] = 128'(uy * vz) - 128'(uz * vy);
      c[1] = 128'(uz * vx) - 128'(ux * vz);
      c[2] = 128'(ux * vy) - 128'(uy * vx);
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i] < 0;
         a[i] = neg[i] ? -c[i] : c[i];
      end
      if ((a[0] | a[1] | a[2]) == 0) begin
         w = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
         return w;
      end
      while (((a[0] | a[1] | a[2]) >> 31) != 0)
         for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      for (int i = 0; i < 3; i++) m[i] = a[i][63:0];
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      w.degenerate = 1'b0;
      q = unit_component(m[0], s); w.nx = neg[0] ? -q[15:0] : q[15:0];
      q = unit_component(m[1], s); w.ny = neg[1] ? -q[15:0] : q[15:0];
      q = unit_component(m[2], s); w.nz = neg[2] ? -q[15:0] : q[15:0];
      return w;
   endfunction

   always @(posedge clock) begin
      normal_word_type e;
      tri_type t;
      if (reset) begin
         normal_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (normal_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected word nx=%0d", rsp_ch.nx);
               fail_count <= fail_count + 1;
            end else begin
               e = normal_queue.pop_front();
               if (e.nx !== rsp_ch.nx || e.ny !== rsp_ch.ny || e.nz !== rsp_ch.nz
                   || e.degenerate !== rsp_ch.degenerate) begin
                  if (fail_count < 10)
                     $display("mismatch exp %0d %0d %0d %b got %0d %0d %0d %b",
                              e.nx, e.ny, e.nz, e.degenerate, rsp_ch.nx, rsp_ch.ny,
                              rsp_ch.nz, rsp_ch.degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            t = '{req_ch.ax, req_ch.ay, req_ch.az, req_ch.bx, req_ch.by_coord,
                  req_ch.bz, req_ch.cx, req_ch.cy, req_ch.cz};
            normal_queue.push_back(face_normal(t));
         end
      end
   end

   assign pending = normal_queue.size();
endmodule

>>> tb/triangle_unit_normal_tb.sv
// testbench top: clock, reset, triangle stimulus and verdict
module triangle_unit_normal_tb;
   import tun_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending;
   int   send_idle = 0;
   int   recv_idle = 0;

   tun_req_if req_ch();
   tun_rsp_if rsp_ch();

   triangle_unit_normal i_dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));
   triangle_unit_normal_checker i_checker (.clock(clock), .reset(reset), .req_ch(req_ch),
      .rsp_ch(rsp_ch), .fail_count(fail_count), .pending(pending));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver stalls
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 1023)) - 512);
         default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   task automatic send(tri_type t);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.ax, req_ch.ay, req_ch.az, req_ch.bx, req_ch.by_coord, req_ch.bz,
       req_ch.cx, req_ch.cy, req_ch.cz} <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      int mode;
      tri_type t;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(9);
         if (mode < 5) t = tri_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         else if (mode < 8) begin
            t.ax = rand_coord(1); t.ay = rand_coord(1); t.az = rand_coord(1);
            t.bx = rand_coord(1); t.by_coord = rand_coord(1); t.bz = rand_coord(1);
            t.cx = rand_coord(1); t.cy = rand_coord(1); t.cz = rand_coord(1);
         end else if (mode == 8) begin
            t.ax = rand_coord(2); t.ay = rand_coord(2); t.az = rand_coord(2);
            t.bx = rand_coord(2); t.by_coord = rand_coord(2); t.bz = rand_coord(2);
            t.cx = rand_coord(2); t.cy = rand_coord(2); t.cz = rand_coord(2);
         end else begin
            // collinear points
            t.ax = rand_coord(1); t.ay = rand_coord(1); t.az = rand_coord(1);
            t.bx = coord_type'(t.ax + 2); t.by_coord = coord_type'(t.ay + 4);
            t.bz = coord_type'(t.az - 6);
            t.cx = coord_type'(t.ax + 3); t.cy = coord_type'(t.ay + 6);
            t.cz = coord_type'(t.az - 9);
         end
         send(t);
      end
   endtask

   initial begin
      req_ch.valid = 0;
      {req_ch.ax, req_ch.ay, req_ch.az, req_ch.bx, req_ch.by_coord, req_ch.bz,
       req_ch.cx, req_ch.cy, req_ch.cz} = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // degenerate cases
      send('0);
      send('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh7fff, 16'sh7fff, 16'sh7fff});
      send('{16'sd100, 16'sd0, 16'sd0, 16'sd200, 16'sd0, 16'sd0, 16'sd300, 16'sd0, 16'sd0});
      // axis-aligned normals, both signs
      send('{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0});
      send('{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0});
      send('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd256});
      send('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0, 16'sd256});
      // extreme spans
      send('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
             16'sh7fff, 16'sh7fff, 16'sh8000});
      send('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
             16'sh7fff, 16'sh7fff, 16'sh8000});
      // tiny component next to a huge one
      send('{16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd1, 16'sh7fff, 16'sh7fff, 16'sd1});
      send('{16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd1});
      send('{16'sd1, -16'sd3, 16'sd5, -16'sd7, 16'sd11, -16'sd13, 16'sd17, -16'sd19, 16'sd23});
      send_idle = 28; recv_idle = 56;
      send_random(200);
      // hold off until the pipeline drains
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      send_idle = 56; recv_idle = 28;
      send_random(200);
      send_idle = 0; recv_idle = 0;
      send_random(200);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end
endmodule
